[rtl/ipdd_pkg.sv]
`default_nettype none

package ipdd_pkg;

    localparam int unsigned HDR_LEN = 5;
    localparam int unsigned LEN_W   = 17;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } result_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                3'd0:    c = 8'h2B;
                3'd1:    c = 8'h49;
                3'd2:    c = 8'h50;
                3'd3:    c = 8'h44;
                3'd4:    c = 8'h2C;
                default: c = 8'h2B;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/ipdd_parse.sv]
`default_nettype none

module ipdd_parse #(
    parameter int unsigned LENGTH_DIGITS = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          rx_byte,
    output ipdd_pkg::result_t        result
);

    localparam int unsigned DC_W = $clog2(LENGTH_DIGITS + 1);
    localparam int unsigned LW   = ipdd_pkg::LEN_W;

    ipdd_pkg::phase_t  phase_reg, phase_next;
    logic [2:0]        hidx_reg, hidx_next;
    logic [DC_W-1:0]   dcnt_reg, dcnt_next;
    logic              frozen_reg, frozen_next;
    logic [LW-1:0]     flen_reg, flen_next;
    logic [LW-1:0]     bpass_reg, bpass_next;

    logic [LW-1:0]     bp_inc;
    logic [LW+3:0]     acc;
    logic [2:0]        hidx_eff;
    logic              is_digit;

    assign bp_inc   = bpass_reg + LW'(1);
    assign is_digit = (rx_byte >= ipdd_pkg::CH_ZERO) && (rx_byte <= ipdd_pkg::CH_NINE);
    assign acc      = {1'b0, flen_reg, 3'b000} + {3'b000, flen_reg, 1'b0}
                    + (LW+4)'(rx_byte - ipdd_pkg::CH_ZERO);
    assign hidx_eff = (hidx_reg >= 3'(ipdd_pkg::HDR_LEN)) ? 3'd0 : hidx_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        dcnt_next   = dcnt_reg;
        frozen_next = frozen_reg;
        flen_next   = flen_reg;
        bpass_next  = bpass_reg;
        result      = '0;
        result.data = rx_byte;
        if (step)
        begin
            unique case (phase_reg)
                ipdd_pkg::PH_DATA:
                begin
                    result.valid = 1'b1;
                    result.last  = (bp_inc == flen_reg);
                    bpass_next   = bp_inc;
                    if (bp_inc == flen_reg)
                    begin
                        phase_next  = ipdd_pkg::PH_HUNT;
                        hidx_next   = 3'd0;
                        dcnt_next   = '0;
                        frozen_next = 1'b0;
                        flen_next   = '0;
                        bpass_next  = '0;
                    end
                end
                ipdd_pkg::PH_LEN:
                begin
                    if (rx_byte == ipdd_pkg::CH_COLON)
                    begin
                        bpass_next = '0;
                        if (flen_reg == '0)
                        begin
                            phase_next  = ipdd_pkg::PH_HUNT;
                            hidx_next   = 3'd0;
                            dcnt_next   = '0;
                            frozen_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = ipdd_pkg::PH_DATA;
                        end
                    end
                    else if (dcnt_reg < DC_W'(LENGTH_DIGITS))
                    begin
                        dcnt_next = dcnt_reg + DC_W'(1);
                        if (!frozen_reg)
                        begin
                            if (is_digit)
                                flen_next = (acc > (LW+4)'(ipdd_pkg::LEN_MAX)) ?
                                            ipdd_pkg::LEN_MAX : acc[LW-1:0];
                            else
                                frozen_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = ipdd_pkg::PH_HUNT;
                    if (ipdd_pkg::hdr_char(hidx_eff) == rx_byte)
                    begin
                        hidx_next = hidx_eff + 3'd1;
                        if (hidx_eff == 3'(ipdd_pkg::HDR_LEN - 1))
                        begin
                            phase_next  = ipdd_pkg::PH_LEN;
                            hidx_next   = 3'd0;
                            dcnt_next   = '0;
                            frozen_next = 1'b0;
                            flen_next   = '0;
                            bpass_next  = '0;
                        end
                    end
                    else
                    begin
                        hidx_next = 3'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ipdd_pkg::PH_HUNT;
            hidx_reg   <= 3'd0;
            dcnt_reg   <= '0;
            frozen_reg <= 1'b0;
            flen_reg   <= '0;
            bpass_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            dcnt_reg   <= dcnt_next;
            frozen_reg <= frozen_next;
            flen_reg   <= flen_next;
            bpass_reg  <= bpass_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ipd_payload_deframer.sv]
// Payload deframer for a modem receive stream. Takes one received byte per beat
// on rx, hunts for the "+IPD," header, reads the decimal length up to ':' (first
// LENGTH_DIGITS characters, a non-digit freezes the value, saturating at 131071)
// and forwards exactly that many bytes on payload, last_of_frame marking the
// final one. A zero length goes back to hunting with nothing sent. One byte per
// clock while rx_ready is high: the parser updates its state in the cycle a byte
// is accepted and the beat appears in the next cycle from the output register;
// rx_ready drops only while that register holds a beat payload_ready has not taken.
`default_nettype none

module ipd_payload_deframer #(
    parameter int unsigned LENGTH_DIGITS = 5
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            payload_valid,
    input  wire logic       payload_ready,
    output logic [7:0]      payload_byte,
    output logic            last_of_frame
);

    ipdd_pkg::result_t result;
    logic              step;
    logic              ovalid_reg;
    logic [7:0]        obyte_reg;
    logic              olast_reg;

    assign rx_ready = !ovalid_reg || payload_ready;
    assign step     = rx_valid && rx_ready;

    ipdd_parse #(
        .LENGTH_DIGITS(LENGTH_DIGITS)
    ) u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .rx_byte(rx_byte),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (rx_ready)
            ovalid_reg <= result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            obyte_reg <= result.data;
            olast_reg <= result.last;
        end
    end

    assign payload_valid = ovalid_reg;
    assign payload_byte  = obyte_reg;
    assign last_of_frame = olast_reg;

endmodule

`default_nettype wire

[rtl/ipdd_checker.sv]
`default_nettype none

module ipdd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rx_valid,
    input wire logic       rx_ready,
    input wire logic       payload_valid,
    input wire logic       payload_ready,
    input wire logic [7:0] payload_byte,
    input wire logic       last_of_frame
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        payload_valid && !payload_ready |=>
            payload_valid && $stable(payload_byte) && $stable(last_of_frame))
        else $error("payload beat changed while stalled");

    // empty output never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !payload_valid |-> rx_ready)
        else $error("rx stalled with empty output");

    // a rising payload_valid comes from an accepted rx beat
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(payload_valid) |-> $past(rx_valid && rx_ready))
        else $error("payload beat without rx beat");

    // taken beat with no new rx beat leaves output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        payload_valid && payload_ready && !(rx_valid && rx_ready) |=> !payload_valid)
        else $error("payload beat repeated");

endmodule

bind ipd_payload_deframer ipdd_checker u_ipdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .payload_valid(payload_valid),
    .payload_ready(payload_ready),
    .payload_byte (payload_byte),
    .last_of_frame(last_of_frame)
);

`default_nettype wire

[tb/tb_ipd_payload_deframer.sv]
`timescale 1ns / 100ps

module tb_ipd_payload_deframer;

    localparam int DIGITS   = 5;
    localparam int N_ITEMS  = 1450;
    localparam int SHOW_MAX = 10;
    localparam logic [8*ipdd_pkg::HDR_LEN-1:0] HDR_TEXT = "+IPD,";

    typedef struct {
        logic [7:0] b;
        bit         drain;
    } rx_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } payload_beat_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       rx_valid      = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte       = 8'h00;
    logic       payload_valid;
    logic       payload_ready = 1'b0;
    logic [7:0] payload_byte;
    logic       last_of_frame;

    rx_item_t      rx_q[$];
    payload_beat_t expected_q[$];

    // parser state as predicted
    ipdd_pkg::phase_t           parse_phase;
    logic [2:0]                 hdr_idx;
    logic [2:0]                 n_chars;
    logic                       len_frozen;
    logic [ipdd_pkg::LEN_W-1:0] frame_len;
    logic [ipdd_pkg::LEN_W-1:0] sent_cnt;

    int beats_in     = 0;
    int beats_out    = 0;
    int frames_done  = 0;
    int err_count    = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int hold_left    = 0;
    int hold_count   = 0;
    int rx_mode      = 0;
    int mode_left    = 0;
    int next_hold_at = 400;
    int total_items  = 0;

    ipd_payload_deframer #(
        .LENGTH_DIGITS(DIGITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx_valid(rx_valid),
        .rx_ready(rx_ready),
        .rx_byte(rx_byte),
        .payload_valid(payload_valid),
        .payload_ready(payload_ready),
        .payload_byte(payload_byte),
        .last_of_frame(last_of_frame)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    task automatic restart_hunt();
        parse_phase = ipdd_pkg::PH_HUNT;
        hdr_idx     = '0;
        n_chars     = '0;
        len_frozen  = 1'b0;
        frame_len   = '0;
        sent_cnt    = '0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        payload_beat_t beat;
        int unsigned   acc;
        case (parse_phase)
            ipdd_pkg::PH_DATA:
            begin
                sent_cnt  = sent_cnt + 1'b1;
                beat.data = b;
                beat.last = (sent_cnt == frame_len);
                expected_q.push_back(beat);
                if (beat.last)
                begin
                    restart_hunt();
                end
            end
            ipdd_pkg::PH_LEN:
            begin
                if (b == ipdd_pkg::CH_COLON)
                begin
                    if (frame_len == '0)
                    begin
                        restart_hunt();
                    end
                    else
                    begin
                        parse_phase = ipdd_pkg::PH_DATA;
                        sent_cnt    = '0;
                    end
                end
                else if (n_chars < DIGITS)
                begin
                    n_chars = n_chars + 1'b1;
                    if (!len_frozen)
                    begin
                        if (b >= ipdd_pkg::CH_ZERO && b <= ipdd_pkg::CH_NINE)
                        begin
                            acc       = frame_len * 10 + (b - ipdd_pkg::CH_ZERO);
                            frame_len = (acc > ipdd_pkg::LEN_MAX) ? ipdd_pkg::LEN_MAX
                                                                  : acc[ipdd_pkg::LEN_W-1:0];
                        end
                        else
                        begin
                            len_frozen = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                parse_phase = ipdd_pkg::PH_HUNT;
                if (hdr_idx >= ipdd_pkg::HDR_LEN)
                begin
                    hdr_idx = '0;
                end
                if (b == HDR_TEXT[8*ipdd_pkg::HDR_LEN-1 - 8*hdr_idx -: 8])
                begin
                    hdr_idx = hdr_idx + 1'b1;
                    if (hdr_idx == ipdd_pkg::HDR_LEN)
                    begin
                        restart_hunt();
                        parse_phase = ipdd_pkg::PH_LEN;
                    end
                end
                else
                begin
                    hdr_idx = '0;
                end
            end
        endcase
    endtask

    task automatic note_error(input string msg);
        if (err_count < SHOW_MAX)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        err_count++;
    endtask

    task automatic push_byte(input logic [7:0] b, input bit drain);
        rx_item_t it;
        it.b     = b;
        it.drain = drain;
        rx_q.push_back(it);
    endtask

    task automatic push_text(input string s, input bit drain);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s[i], drain && (i == 0));
        end
    endtask

    task automatic push_payload(input int n);
        string special;
        special = "+IPD,:";
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                push_byte(special[$urandom_range(0, 5)], 1'b0);
            end
            else
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : rx_driver
        logic       take;
        logic       next_valid;
        logic [7:0] next_byte;
        if (!rst_n)
        begin
            rx_valid   <= 1'b0;
            rx_byte    <= 8'h00;
            gap_left   <= 0;
            burst_left <= 0;
            restart_hunt();
        end
        else
        begin
            take       = rx_valid && rx_ready;
            next_valid = rx_valid && !take;
            next_byte  = rx_byte;
            if (take)
            begin
                deframe_byte(rx_byte);
                beats_in <= beats_in + 1;
            end
            if (!next_valid && rx_q.size() != 0)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (!(rx_q[0].drain && expected_q.size() != 0))
                begin
                    next_valid = 1'b1;
                    next_byte  = rx_q[0].b;
                    void'(rx_q.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            rx_valid <= next_valid;
            rx_byte  <= next_byte;
        end
    end

    // receiver: checks each beat, stalls on a changing pattern plus long holds
    always @(posedge clk or negedge rst_n)
    begin : payload_monitor
        payload_beat_t want;
        logic          rdy;
        if (!rst_n)
        begin
            payload_ready <= 1'b0;
            hold_left     <= 0;
            rx_mode       <= 0;
            mode_left     <= 0;
        end
        else
        begin
            if (payload_valid && payload_ready)
            begin
                beats_out <= beats_out + 1;
                if (last_of_frame)
                begin
                    frames_done <= frames_done + 1;
                end
                if (expected_q.size() == 0)
                begin
                    note_error($sformatf("unexpected beat data=%02h last=%0b",
                                         payload_byte, last_of_frame));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.data !== payload_byte || want.last !== last_of_frame)
                    begin
                        note_error($sformatf("data exp %02h got %02h, last exp %0b got %0b",
                                             want.data, payload_byte, want.last,
                                             last_of_frame));
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rdy = 1'b0;
            end
            else if (beats_in >= next_hold_at)
            begin
                hold_left    <= 300;
                hold_count   <= hold_count + 1;
                next_hold_at <= next_hold_at + 700;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   <= $urandom_range(0, 2);
                    mode_left <= $urandom_range(10, 80);
                end
                else
                begin
                    mode_left <= mode_left - 1;
                end
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            payload_ready <= rdy;
        end
    end

    initial
    begin : stimulus
        string special;
        string len_txt;
        int    pick;
        int    n;
        int    cut;
        int    good_no;
        bit    drain;
        logic [7:0] junk;
        special = "+IPD,:";
        good_no = 0;

        // header restart without retest, empty length, frozen length with extreme bytes
        push_text("++IPD,", 1'b0);
        push_text("+IPD,:", 1'b0);
        push_text("+IPD,2x:", 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);

        while (rx_q.size() < N_ITEMS + 22)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                good_no++;
                drain = (good_no % 15 == 0);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120)
                                                : $urandom_range(1, 16);
                len_txt = $sformatf("%0d", n);
                if ($urandom_range(0, 4) == 0)
                begin
                    while (len_txt.len() < 5 && $urandom_range(0, 1))
                    begin
                        len_txt = {"0", len_txt};
                    end
                end
                push_text({"+IPD,", len_txt, ":"}, drain);
                push_payload(n);
            end
            else if (pick < 82)
            begin
                n = $urandom_range(0, 9);
                junk = 8'($urandom_range(0, 255));
                while ((junk >= ipdd_pkg::CH_ZERO && junk <= ipdd_pkg::CH_NINE) ||
                       junk == ipdd_pkg::CH_COLON)
                begin
                    junk = 8'($urandom_range(0, 255));
                end
                case ($urandom_range(0, 3))
                    0:
                    begin
                        push_text($sformatf("+IPD,%0d", n), 1'b0);
                        push_byte(junk, 1'b0);
                        push_text($sformatf("%0d:", $urandom_range(0, 99)), 1'b0);
                    end
                    1:
                    begin
                        push_text("+IPD,", 1'b0);
                        push_byte(($urandom_range(0, 1) != 0) ? 8'h2B : junk, 1'b0);
                        push_text($sformatf("%0d:", n), 1'b0);
                    end
                    2:
                    begin
                        push_text($sformatf("+IPD,00000%0d:", n), 1'b0);
                    end
                    default:
                    begin
                        push_text($sformatf("+IPD,0000%0d%0d:", n, $urandom_range(0, 9)),
                                  1'b0);
                    end
                endcase
                push_payload(n);
            end
            else if (pick < 92)
            begin
                cut = $urandom_range(1, 4);
                push_text(special.substr(0, cut - 1), 1'b0);
                push_byte(($urandom_range(0, 1) != 0) ? 8'h2B : 8'($urandom_range(0, 255)),
                          1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
        total_items = rx_q.size();

        @(posedge clk);
        while (beats_in != total_items)
        begin
            @(posedge clk);
        end
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("run: %0d rx beats, %0d payload beats checked, %0d frames closed, %0d long holds",
                 beats_in, beats_out, frames_done, hold_count);
        $display("run: header restarts, frozen and over-long lengths, zero lengths, drains");
        if (err_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches", err_count);
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/ipdd_pkg.sv
rtl/ipdd_parse.sv
rtl/ipd_payload_deframer.sv
rtl/ipdd_checker.sv
tb/tb_ipd_payload_deframer.sv
